// ===== rtl/core/crf_pkg.sv =====
package crf_pkg;

	localparam int unsigned RECORD_BYTES_DEF = 128;
	localparam int unsigned CFG_IDX_W = 8;
	localparam int unsigned GAP_W = 16;
	localparam int unsigned REP_W = 8;
	localparam int unsigned HDR_IDX_W = 4;
	localparam logic [HDR_IDX_W-1:0] HDR_LAST = 4'd9;

	localparam logic [CFG_IDX_W-1:0] REG_GAP_LONG = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GAP_MEDIUM = 8'd1;
	localparam logic [CFG_IDX_W-1:0] REG_GAP_SHORT = 8'd2;
	localparam logic [CFG_IDX_W-1:0] REG_GAP_FAST = 8'd3;

	localparam logic [GAP_W-1:0] GAP_LONG_RST = 16'd14000;
	localparam logic [GAP_W-1:0] GAP_MEDIUM_RST = 16'd422;
	localparam logic [GAP_W-1:0] GAP_SHORT_RST = 16'd250;
	localparam logic [GAP_W-1:0] GAP_FAST_RST = 16'd20;

	localparam logic [7:0] SUM_INIT = 8'hA7;
	localparam logic [7:0] SYNC_BYTE = 8'h55;
	localparam logic [7:0] CTRL_DATA = 8'hFC;
	localparam logic [7:0] CTRL_EOF = 8'hFE;
	localparam logic [7:0] EOF_SUM = 8'hA9;

	typedef struct packed {
		logic       mode;
		logic [7:0] data_byte;
		logic       segment_end;
		logic [1:0] gap_select;
	} crf_item_t;

	typedef struct packed {
		logic [7:0]       out_byte;
		logic [REP_W-1:0] repeat_count;
		logic             frame_end;
		logic             last_result;
	} crf_result_t;

	typedef struct packed {
		logic [CFG_IDX_W-1:0] index;
		logic [GAP_W-1:0]     value;
	} crf_cfg_t;

	// Chunk header: "data", record length, gap, then two sync bytes.
	function automatic logic [7:0] crf_hdr_byte(input logic [HDR_IDX_W-1:0] idx,
		input logic [15:0] len, input logic [GAP_W-1:0] gap);
		logic [7:0] b;
		case (idx)
			4'd0: b = 8'h64;
			4'd1: b = 8'h61;
			4'd2: b = 8'h74;
			4'd3: b = 8'h61;
			4'd4: b = len[7:0];
			4'd5: b = len[15:8];
			4'd6: b = gap[7:0];
			4'd7: b = gap[15:8];
			default: b = SYNC_BYTE;
		endcase
		return b;
	endfunction

endpackage

// ===== rtl/core/crf_chan_if.sv =====
interface crf_chan_if #(parameter type payload_t = logic);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

// ===== rtl/core/cassette_record_framer_top.sv =====
// Channel   Direction  Payload        Transaction
// items     in         crf_item_t     valid & ready at clk rise
// results   out        crf_result_t   valid & ready at clk rise
// cfg       in         crf_cfg_t      valid & ready at clk rise, ready always high
//
// One result leaves the output register per cycle while results.ready is high; an item
// has one result for a plain payload byte and up to 15 results for an end-of-file
// request that closes an open record. The result sequencer sets this number.
// A new item is taken in the cycle the previous item's last result loads the output register.
// Reset returns the sequencer, record state and gap registers to their defaults; results stall on ready.
module cassette_record_framer_top import crf_pkg::*; #(
	parameter int unsigned RECORD_BYTES = RECORD_BYTES_DEF
) (
	input logic clk,
	input logic arst_n,
	crf_chan_if.sink items,
	crf_chan_if.source results,
	crf_chan_if.sink cfg
);

	localparam int unsigned POS_W = $clog2(RECORD_BYTES);
	localparam int unsigned NPOS_W = POS_W + 1;
	localparam logic [NPOS_W-1:0] RB_N = NPOS_W'(RECORD_BYTES);
	localparam logic [15:0] REC_LEN = 16'(RECORD_BYTES + 4);

	typedef enum logic [7:0] {
		ST_IDLE = 8'b0000_0001,
		ST_HDR  = 8'b0000_0010,
		ST_CTRL = 8'b0000_0100,
		ST_DATA = 8'b0000_1000,
		ST_PAD  = 8'b0001_0000,
		ST_CHK  = 8'b0010_0000,
		ST_EOFZ = 8'b0100_0000,
		ST_EOFC = 8'b1000_0000
	} crf_state_t;

	crf_state_t state_q, state_start, state_next;
	logic [HDR_IDX_W-1:0] hdr_q;

	logic [GAP_W-1:0] gap_q [4];

	logic open_q;
	logic [POS_W-1:0] pos_q;
	logic [7:0] sum_q;

	logic it_eof_q, it_close_q, it_pad_q;
	logic [REP_W-1:0] it_left_q;
	logic [7:0] it_chk_q, it_data_q;
	logic [GAP_W-1:0] it_gap_q;

	logic out_valid_q;
	crf_result_t out_q, res_d;

	logic adv, accept;
	logic [NPOS_W-1:0] pos0, pos_new, pos_cur;
	logic [7:0] sum0, sum_new;
	logic [8:0] sum_wide;
	logic close_d;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gap_q[0] <= GAP_LONG_RST;
			gap_q[1] <= GAP_MEDIUM_RST;
			gap_q[2] <= GAP_SHORT_RST;
			gap_q[3] <= GAP_FAST_RST;
		end else if (cfg.valid) begin
			case (cfg.data.index)
				REG_GAP_LONG: gap_q[0] <= cfg.data.value;
				REG_GAP_MEDIUM: gap_q[1] <= cfg.data.value;
				REG_GAP_SHORT: gap_q[2] <= cfg.data.value;
				REG_GAP_FAST: gap_q[3] <= cfg.data.value;
				default: ;
			endcase
		end
	end

	assign pos_cur = {1'b0, pos_q};
	assign pos0 = open_q ? pos_cur : '0;
	assign sum0 = open_q ? sum_q : SUM_INIT;
	assign sum_wide = {1'b0, sum0} + {1'b0, items.data.data_byte};
	assign sum_new = sum_wide[7:0] + {7'b0, sum_wide[8]};
	assign pos_new = pos0 + NPOS_W'(1);
	assign close_d = (pos_new >= RB_N) || items.data.segment_end;

	always_comb begin
		if (items.data.mode) begin
			if (!open_q) begin
				state_start = ST_HDR;
			end else if (pos_cur < RB_N) begin
				state_start = ST_PAD;
			end else begin
				state_start = ST_CHK;
			end
		end else begin
			state_start = open_q ? ST_DATA : ST_HDR;
		end
	end

	always_comb begin
		res_d = '0;
		res_d.repeat_count = REP_W'(1);
		state_next = state_q;
		case (state_q)
			ST_HDR: begin
				res_d.out_byte = crf_hdr_byte(hdr_q, REC_LEN, it_gap_q);
				if (hdr_q == HDR_LAST) begin
					state_next = ST_CTRL;
				end
			end
			ST_CTRL: begin
				res_d.out_byte = it_eof_q ? CTRL_EOF : CTRL_DATA;
				state_next = it_eof_q ? ST_EOFZ : ST_DATA;
			end
			ST_DATA: begin
				res_d.out_byte = it_data_q;
				res_d.last_result = !it_close_q;
				if (!it_close_q) begin
					state_next = ST_IDLE;
				end else begin
					state_next = it_pad_q ? ST_PAD : ST_CHK;
				end
			end
			ST_PAD: begin
				res_d.repeat_count = it_left_q;
				state_next = ST_CHK;
			end
			ST_CHK: begin
				res_d.out_byte = it_chk_q;
				res_d.frame_end = 1'b1;
				res_d.last_result = !it_eof_q;
				state_next = it_eof_q ? ST_HDR : ST_IDLE;
			end
			ST_EOFZ: begin
				res_d.repeat_count = REP_W'(RECORD_BYTES);
				state_next = ST_EOFC;
			end
			ST_EOFC: begin
				res_d.out_byte = EOF_SUM;
				res_d.frame_end = 1'b1;
				res_d.last_result = 1'b1;
				state_next = ST_IDLE;
			end
			default: begin
				state_next = ST_IDLE;
			end
		endcase
	end

	assign adv = (state_q != ST_IDLE) && (!out_valid_q || results.ready);
	assign items.ready = (state_q == ST_IDLE) || (adv && res_d.last_result);
	assign accept = items.valid && items.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			hdr_q <= '0;
			open_q <= 1'b0;
			pos_q <= '0;
			sum_q <= SUM_INIT;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				state_q <= state_start;
			end else if (adv) begin
				state_q <= state_next;
			end
			if (accept || (adv && state_q != ST_HDR)) begin
				hdr_q <= '0;
			end else if (adv) begin
				hdr_q <= hdr_q + HDR_IDX_W'(1);
			end
			if (accept) begin
				if (items.data.mode || close_d) begin
					open_q <= 1'b0;
					pos_q <= '0;
					sum_q <= SUM_INIT;
				end else begin
					open_q <= 1'b1;
					pos_q <= pos_new[POS_W-1:0];
					sum_q <= sum_new;
				end
			end
			if (adv) begin
				out_valid_q <= 1'b1;
			end else if (results.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			it_eof_q <= items.data.mode;
			it_close_q <= close_d;
			it_data_q <= items.data.data_byte;
			it_gap_q <= gap_q[items.data.gap_select];
			if (items.data.mode) begin
				it_pad_q <= open_q && (pos_cur < RB_N);
				it_left_q <= REP_W'(RB_N - pos_cur);
				it_chk_q <= sum_q;
			end else begin
				it_pad_q <= pos_new < RB_N;
				it_left_q <= REP_W'(RB_N - pos_new);
				it_chk_q <= sum_new;
			end
		end
		if (adv) begin
			out_q <= res_d;
		end
	end

	assign results.valid = out_valid_q;
	assign results.data = out_q;

`ifndef ASSERT_OFF
	a_open_pos: assert property (@(posedge clk) disable iff (!arst_n)
		open_q |-> (pos_q != '0 && pos_cur < RB_N))
		else $error("open record has a bad byte position");

	a_closed_clean: assert property (@(posedge clk) disable iff (!arst_n)
		!open_q |-> (pos_q == '0 && sum_q == SUM_INIT))
		else $error("closed record left stale position or checksum");

	a_zero_run: assert property (@(posedge clk) disable iff (!arst_n)
		(results.valid && results.data.repeat_count != REP_W'(1)) |->
		(results.data.out_byte == 8'h00 && results.data.repeat_count != '0))
		else $error("repeat run is not a nonempty zero run");

	a_take_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(items.valid && items.ready && state_q != ST_IDLE) |=>
		(results.valid && results.data.last_result))
		else $error("item taken before the previous item's last result");
`endif

endmodule

// ===== tb/sv/tb.sv =====
module tb;
	import crf_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned REC = RECORD_BYTES_DEF;
	localparam int unsigned HOLD_OFF = 24;
	localparam int unsigned QUIET_LIMIT = 3000;
	localparam int unsigned PHASE_ITEMS = 28;

	localparam logic MODE_DATA = 1'b0;
	localparam logic MODE_EOF = 1'b1;

	localparam logic [7:0] TAG_D = 8'h64;
	localparam logic [7:0] TAG_A = 8'h61;
	localparam logic [7:0] TAG_T = 8'h74;
	localparam logic [7:0] PAD_BYTE = 8'h00;

	// Predicts the tape image stream and checks the block's results in order.
	class framer_scoreboard;
		logic [GAP_W-1:0] gap_ms [4];
		int unsigned      fill;
		logic [7:0]       csum;
		bit               open;
		crf_result_t      pending_q [$];
		int unsigned      errors;

		function new();
			gap_ms[0] = GAP_LONG_RST;
			gap_ms[1] = GAP_MEDIUM_RST;
			gap_ms[2] = GAP_SHORT_RST;
			gap_ms[3] = GAP_FAST_RST;
			fill = 0;
			csum = SUM_INIT;
			open = 0;
			errors = 0;
		endfunction

		function void write_gap(logic [CFG_IDX_W-1:0] idx, logic [GAP_W-1:0] value);
			case (idx)
				REG_GAP_LONG: gap_ms[0] = value;
				REG_GAP_MEDIUM: gap_ms[1] = value;
				REG_GAP_SHORT: gap_ms[2] = value;
				REG_GAP_FAST: gap_ms[3] = value;
				default: ;
			endcase
		endfunction

		function void push(logic [7:0] b, logic [REP_W-1:0] n, logic fe);
			crf_result_t r;
			r.out_byte = b;
			r.repeat_count = n;
			r.frame_end = fe;
			r.last_result = 1'b0;
			pending_q.push_back(r);
		endfunction

		function void push_header(logic [1:0] sel);
			logic [15:0]      len;
			logic [GAP_W-1:0] g;
			len = 16'(REC + 4);
			g = gap_ms[sel];
			push(TAG_D, 1, 0);
			push(TAG_A, 1, 0);
			push(TAG_T, 1, 0);
			push(TAG_A, 1, 0);
			push(len[7:0], 1, 0);
			push(len[15:8], 1, 0);
			push(g[7:0], 1, 0);
			push(g[15:8], 1, 0);
			push(SYNC_BYTE, 1, 0);
			push(SYNC_BYTE, 1, 0);
		endfunction

		function void close_record();
			if (fill < REC)
				push(PAD_BYTE, REP_W'(REC - fill), 0);
			push(csum, 1, 1);
			open = 0;
			fill = 0;
			csum = SUM_INIT;
		endfunction

		function void note_item(crf_item_t it);
			logic [8:0]  acc;
			crf_result_t r;
			if (it.mode == MODE_EOF) begin
				if (open)
					close_record();
				push_header(it.gap_select);
				push(CTRL_EOF, 1, 0);
				push(PAD_BYTE, REP_W'(REC), 0);
				push(EOF_SUM, 1, 1);
			end else begin
				if (!open) begin
					push_header(it.gap_select);
					push(CTRL_DATA, 1, 0);
					open = 1;
					fill = 0;
					csum = SUM_INIT;
				end
				push(it.data_byte, 1, 0);
				acc = {1'b0, csum} + {1'b0, it.data_byte};
				csum = acc[7:0] + {7'd0, acc[8]};
				fill++;
				if (fill >= REC || it.segment_end)
					close_record();
			end
			r = pending_q.pop_back();
			r.last_result = 1'b1;
			pending_q.push_back(r);
		endfunction

		function void check_result(crf_result_t got);
			crf_result_t exp_r;
			if (pending_q.size() == 0) begin
				errors++;
				$display("%0t: unexpected result byte %h count %0d frame_end %b last %b",
					$time, got.out_byte, got.repeat_count, got.frame_end, got.last_result);
				return;
			end
			exp_r = pending_q.pop_front();
			if (got.out_byte !== exp_r.out_byte) begin
				errors++;
				$display("%0t: out_byte expected %h actual %h", $time, exp_r.out_byte,
					got.out_byte);
			end
			if (got.repeat_count !== exp_r.repeat_count) begin
				errors++;
				$display("%0t: repeat_count expected %0d actual %0d", $time,
					exp_r.repeat_count, got.repeat_count);
			end
			if (got.frame_end !== exp_r.frame_end) begin
				errors++;
				$display("%0t: frame_end expected %b actual %b", $time, exp_r.frame_end,
					got.frame_end);
			end
			if (got.last_result !== exp_r.last_result) begin
				errors++;
				$display("%0t: last_result expected %b actual %b", $time, exp_r.last_result,
					got.last_result);
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;

	crf_chan_if #(.payload_t(crf_item_t)) items_if ();
	crf_chan_if #(.payload_t(crf_result_t)) results_if ();
	crf_chan_if #(.payload_t(crf_cfg_t)) cfg_if ();

	framer_scoreboard sb = new();

	int unsigned idle_pct;
	int unsigned stall_pct;
	int unsigned items_sent;
	int unsigned quiet;

	cassette_record_framer_top i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.items(items_if),
		.results(results_if),
		.cfg(cfg_if)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		if (!arst_n)
			results_if.ready <= 1'b0;
		else
			results_if.ready <= ($urandom_range(99) >= stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (items_if.valid && items_if.ready)
				sb.note_item(items_if.data);
			if (results_if.valid && results_if.ready)
				sb.check_result(results_if.data);
			if (cfg_if.valid && cfg_if.ready)
				sb.write_gap(cfg_if.data.index, cfg_if.data.value);
		end
	end

	always @(posedge clk) begin
		if ((items_if.valid && items_if.ready) || (results_if.valid && results_if.ready) ||
			(cfg_if.valid && cfg_if.ready)) begin
			quiet = 0;
		end else begin
			quiet++;
			if (quiet >= QUIET_LIMIT) begin
				$display("%0t: no transaction for %0d cycles", $time, quiet);
				$display("FAILURE");
				$finish;
			end
		end
	end

	function automatic crf_item_t make_item(logic m, logic [7:0] d, logic se, logic [1:0] gs);
		crf_item_t it;
		it.mode = m;
		it.data_byte = d;
		it.segment_end = se;
		it.gap_select = gs;
		return it;
	endfunction

	task automatic send_item(input crf_item_t it);
		while ($urandom_range(99) < idle_pct) begin
			items_if.valid <= 1'b0;
			@(posedge clk);
		end
		items_if.valid <= 1'b1;
		items_if.data <= it;
		@(posedge clk);
		while (!items_if.ready)
			@(posedge clk);
		items_sent++;
	endtask

	task automatic hold_until_empty();
		items_if.valid <= 1'b0;
		@(posedge clk);
		while (sb.pending_q.size() != 0)
			@(posedge clk);
	endtask

	task automatic drain();
		hold_until_empty();
		repeat (HOLD_OFF) @(posedge clk);
	endtask

	task automatic write_gaps(input logic [GAP_W-1:0] g_long, input logic [GAP_W-1:0] g_med,
		input logic [GAP_W-1:0] g_short, input logic [GAP_W-1:0] g_fast);
		logic [GAP_W-1:0]     vals [4];
		logic [CFG_IDX_W-1:0] idxs [4];
		int                   i;
		vals = '{g_long, g_med, g_short, g_fast};
		idxs = '{REG_GAP_LONG, REG_GAP_MEDIUM, REG_GAP_SHORT, REG_GAP_FAST};
		for (i = 0; i < 4; i++) begin
			cfg_if.valid <= 1'b1;
			cfg_if.data <= '{index: idxs[i], value: vals[i]};
			@(posedge clk);
			while (!cfg_if.ready)
				@(posedge clk);
		end
		cfg_if.valid <= 1'b0;
	endtask

	task automatic run_directed();
		send_item(make_item(MODE_EOF, 8'h00, 1'b0, 2'd0));
		send_item(make_item(MODE_EOF, 8'hFF, 1'b1, 2'd3));
		send_item(make_item(MODE_DATA, 8'h00, 1'b1, 2'd1));
		send_item(make_item(MODE_DATA, 8'hFF, 1'b0, 2'd2));
		send_item(make_item(MODE_DATA, 8'hFF, 1'b0, 2'd0));
		send_item(make_item(MODE_DATA, 8'hFF, 1'b1, 2'd3));
		send_item(make_item(MODE_DATA, 8'h5A, 1'b0, 2'd3));
		send_item(make_item(MODE_EOF, 8'hA5, 1'b1, 2'd1));
		send_item(make_item(MODE_DATA, 8'h01, 1'b0, 2'd0));
		send_item(make_item(MODE_DATA, 8'h80, 1'b0, 2'd2));
		send_item(make_item(MODE_DATA, 8'h7F, 1'b1, 2'd1));
		send_item(make_item(MODE_DATA, 8'h59, 1'b0, 2'd2));
		send_item(make_item(MODE_EOF, 8'h00, 1'b0, 2'd2));
		send_item(make_item(MODE_EOF, 8'h00, 1'b0, 2'd1));
	endtask

	task automatic run_phase(input int unsigned quota, input bit with_full, input bit pause);
		int unsigned start;
		int unsigned pick;
		int unsigned seg_len;
		int unsigned k;
		bit          paused;
		start = items_sent;
		paused = 0;
		// Two back-to-back full records: the first fills without a segment end,
		// the second ends its segment on the byte that fills it.
		if (with_full) begin
			for (k = 0; k < 2 * REC; k++)
				send_item(make_item(MODE_DATA, 8'($urandom_range(255)), k == 2 * REC - 1,
					2'($urandom_range(3))));
		end
		while (items_sent - start < quota) begin
			pick = $urandom_range(99);
			if (pick < 8) begin
				send_item(make_item(MODE_EOF, 8'($urandom_range(255)), 1'($urandom_range(1)),
					2'($urandom_range(3))));
			end else if (pick < 18) begin
				send_item(make_item(1'($urandom_range(1)), 8'($urandom_range(255)),
					1'($urandom_range(1)), 2'($urandom_range(3))));
			end else begin
				pick = $urandom_range(99);
				if (pick < 70)
					seg_len = $urandom_range(8, 1);
				else if (pick < 96)
					seg_len = $urandom_range(40, 9);
				else
					seg_len = $urandom_range(REC + 12, REC - 12);
				for (k = 0; k < seg_len; k++)
					send_item(make_item(MODE_DATA, 8'($urandom_range(255)), k == seg_len - 1,
						2'($urandom_range(3))));
			end
			if (pause && !paused && items_sent - start >= quota / 2) begin
				hold_until_empty();
				paused = 1;
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		items_if.valid = 1'b0;
		items_if.data = '0;
		cfg_if.valid = 1'b0;
		cfg_if.data = '0;
		idle_pct = 0;
		stall_pct = 0;
		items_sent = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		run_directed();
		drain();

		write_gaps(16'h0000, 16'hFFFF, 16'h00FF, 16'hFF00);
		run_phase(PHASE_ITEMS, 1'b1, 1'b0);
		drain();

		idle_pct = 86;
		write_gaps(16'hFFFF, 16'h0000, 16'($urandom_range(65535)), 16'($urandom_range(65535)));
		run_phase(PHASE_ITEMS, 1'b0, 1'b1);
		drain();

		idle_pct = 0;
		stall_pct = 86;
		write_gaps(16'($urandom_range(65535)), 16'($urandom_range(65535)),
			16'($urandom_range(65535)), 16'($urandom_range(65535)));
		run_phase(PHASE_ITEMS, 1'b0, 1'b0);
		drain();

		idle_pct = 9;
		stall_pct = 9;
		write_gaps(16'h0001, 16'h8000, 16'h7FFF, 16'hFFFE);
		run_phase(PHASE_ITEMS, 1'b0, 1'b0);
		drain();

		if (sb.errors == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
